[rtl/csfu_pkg.sv]
// ----------------------------------------------------------------------------
// csfu_pkg
// Shared types and constants of the closest-string fitness updater.
// ----------------------------------------------------------------------------
package csfu_pkg;

  // fixed field widths
  localparam int unsigned REQ_W      = 2;
  localparam int unsigned REF_W      = 4;
  localparam int unsigned POS_W      = 8;
  localparam int unsigned SYM_W      = 8;
  localparam int unsigned MAX_DIST_W = 9;

  // request type codes on the input channel
  localparam logic [REQ_W-1:0] REQ_LOAD  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_BEGIN = 2'd1;
  localparam logic [REQ_W-1:0] REQ_SET   = 2'd2;

  // classified operation handed from front to back
  typedef enum logic [1:0] {
    OP_NONE,
    OP_LOAD,
    OP_BEGIN,
    OP_SET
  } op_e;

  typedef struct packed {
    op_e              op;
    logic [REF_W-1:0] ref_idx;
    logic [POS_W-1:0] pos;
    logic [SYM_W-1:0] sym;
  } item_t;

endpackage

[rtl/closest_string_fitness_updater.sv]
// ----------------------------------------------------------------------------
// closest_string_fitness_updater
// Maximum Hamming distance of a candidate string against a reference table.
// ----------------------------------------------------------------------------
// flow: a load, begin or ignored item goes from the queue through the idle
//   and result states; a set item also walks the counters and drains
// throughput: the back takes one item at a time and, during a set, reads and
//   writes one reference counter per cycle; the queue takes items until full
// reset: queue and output empty, all candidate positions unset, all counters
//   and the maximum at LENGTH; no clearing pass, items accepted at once
module closest_string_fitness_updater import csfu_pkg::*; #(
  parameter int unsigned REFS   = 16,
  parameter int unsigned LENGTH = 256
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // request channel
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [REQ_W-1:0]      req_type_i,
  input  logic [REF_W-1:0]      ref_index_i,
  input  logic [POS_W-1:0]      position_i,
  input  logic [SYM_W-1:0]      symbol_i,
  // result channel
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [MAX_DIST_W-1:0] max_distance_o
);

  // queue between front and back
  logic  q_valid;
  logic  q_pop;
  item_t q_item;

  // front: range checks, request decode, two-entry queue
  csfu_front #(
    .REFS   (REFS),
    .LENGTH (LENGTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .req_type_i  (req_type_i),
    .ref_index_i (ref_index_i),
    .position_i  (position_i),
    .symbol_i    (symbol_i),
    .q_valid_o   (q_valid),
    .q_item_o    (q_item),
    .q_pop_i     (q_pop)
  );

  // back: reference table, candidate store, counter walk, result register
  csfu_back #(
    .REFS   (REFS),
    .LENGTH (LENGTH)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_valid_i      (q_valid),
    .q_item_i       (q_item),
    .q_pop_o        (q_pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .max_distance_o (max_distance_o)
  );

endmodule

[rtl/csfu_front.sv]
// ----------------------------------------------------------------------------
// csfu_front
// Accepts items, classifies them and buffers them in a two-entry queue.
// ----------------------------------------------------------------------------
module csfu_front import csfu_pkg::*; #(
  parameter int unsigned REFS   = 16,
  parameter int unsigned LENGTH = 256
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [REQ_W-1:0] req_type_i,
  input  logic [REF_W-1:0] ref_index_i,
  input  logic [POS_W-1:0] position_i,
  input  logic [SYM_W-1:0] symbol_i,
  output logic             q_valid_o,
  output item_t            q_item_o,
  input  logic             q_pop_i
);

  op_e        op;
  item_t      slot_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       push, pos_ok, ref_ok;

  assign pos_ok = 32'(position_i) < LENGTH;
  assign ref_ok = 32'(ref_index_i) < REFS;

  always_comb begin
    unique case (req_type_i)
      REQ_LOAD:  op = (pos_ok && ref_ok) ? OP_LOAD : OP_NONE;
      REQ_BEGIN: op = OP_BEGIN;
      REQ_SET:   op = pos_ok ? OP_SET : OP_NONE;
      default:   op = OP_NONE;
    endcase
  end

  assign in_stall_o = cnt_q == 2'd2;
  assign push       = in_valid_i && !in_stall_o;
  assign q_valid_o  = cnt_q != 2'd0;
  assign q_item_o   = slot_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_q] <= '{op: op, ref_idx: ref_index_i, pos: position_i, sym: symbol_i};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wr_q <= !wr_q;
      if (q_pop_i) rd_q <= !rd_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop_i};
    end
  end

  a_fill_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && !q_pop_i |=> cnt_q == $past(cnt_q) + 2'd1)
    else $error("queue fill count missed a push");

endmodule

[rtl/csfu_back.sv]
// ----------------------------------------------------------------------------
// csfu_back
// Executes queued requests: reference loads, candidate restarts and symbol
// updates that walk the distance counters one reference per cycle.
// ----------------------------------------------------------------------------
module csfu_back import csfu_pkg::*; #(
  parameter int unsigned REFS   = 16,
  parameter int unsigned LENGTH = 256
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  q_valid_i,
  input  item_t                 q_item_i,
  output logic                  q_pop_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [MAX_DIST_W-1:0] max_distance_o
);

  localparam int unsigned CAND_N = (LENGTH < 256) ? LENGTH : 256;
  localparam int unsigned PW     = (CAND_N > 1) ? $clog2(CAND_N) : 1;
  localparam int unsigned KW     = $clog2(REFS);
  localparam int unsigned CW     = $clog2(LENGTH + 1);
  localparam logic [CW-1:0] LEN_C  = CW'(LENGTH);
  localparam logic [KW-1:0] LAST_K = KW'(REFS - 1);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_WALK   = 4'b0010,
    ST_DRAIN  = 4'b0100,
    ST_RESULT = 4'b1000
  } state_e;

  state_e state_q, state_d;

  // storage
  logic [SYM_W-1:0] ref_mem  [REFS][CAND_N];
  logic [SYM_W-1:0] cand_mem [CAND_N];
  logic [CW-1:0]    cnt_mem  [REFS];
  logic [CAND_N-1:0] cset_q;
  logic [REFS-1:0]   cval_q;
  logic [CW-1:0]     worst_q, acc_q;

  // per-update context
  logic [PW-1:0]    pos_q;
  logic [SYM_W-1:0] sym_q, cand_old_q;
  logic             had_q;
  logic [KW-1:0]    k_q;

  // read stage
  logic             p_vld_q;
  logic [KW-1:0]    p_idx_q;
  logic [SYM_W-1:0] ref_rd_q;
  logic [CW-1:0]    cnt_rd_q;
  logic             cval_rd_q;

  logic [CW-1:0]    c_cur, c_new, acc_nxt;
  logic             old_m, new_m, out_free;
  logic             out_valid_q;
  logic [MAX_DIST_W-1:0] out_max_q;

  logic [PW-1:0] head_pos;
  assign head_pos = PW'(q_item_i.pos);

  assign q_pop_o  = (state_q == ST_IDLE) && q_valid_i;
  assign out_free = !out_valid_q || !out_stall_i;

  // counter update for one reference
  always_comb begin
    c_cur = cval_rd_q ? cnt_rd_q : LEN_C;
    old_m = had_q && (ref_rd_q == cand_old_q);
    new_m = ref_rd_q == sym_q;
    c_new = c_cur;
    if (old_m && !new_m && c_cur < LEN_C) begin
      c_new = c_cur + CW'(1);
    end else if (new_m && !old_m && c_cur != '0) begin
      c_new = c_cur - CW'(1);
    end
    acc_nxt = (c_new > acc_q) ? c_new : acc_q;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (q_valid_i) state_d = (q_item_i.op == OP_SET) ? ST_WALK : ST_RESULT;
      end
      ST_WALK: begin
        if (k_q == LAST_K) state_d = ST_DRAIN;
      end
      ST_DRAIN:  state_d = ST_RESULT;
      ST_RESULT: begin
        if (out_free) state_d = ST_IDLE;
      end
      default:   state_d = ST_IDLE;
    endcase
  end

  // memories and payload
  always_ff @(posedge clk_i) begin
    if (q_pop_o && q_item_i.op == OP_LOAD) begin
      ref_mem[KW'(q_item_i.ref_idx)][head_pos] <= q_item_i.sym;
    end
    if (state_q == ST_IDLE) begin
      pos_q      <= head_pos;
      sym_q      <= q_item_i.sym;
      cand_old_q <= cand_mem[head_pos];
      had_q      <= cset_q[head_pos];
    end
    ref_rd_q  <= ref_mem[k_q][pos_q];
    cnt_rd_q  <= cnt_mem[k_q];
    cval_rd_q <= cval_q[k_q];
    p_idx_q   <= k_q;
    if (p_vld_q) cnt_mem[p_idx_q] <= c_new;
    if (state_q == ST_DRAIN) cand_mem[pos_q] <= sym_q;
    if (state_q == ST_RESULT && out_free) out_max_q <= MAX_DIST_W'(worst_q);
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      k_q         <= '0;
      p_vld_q     <= 1'b0;
      cset_q      <= '0;
      cval_q      <= '0;
      worst_q     <= LEN_C;
      acc_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      p_vld_q <= state_q == ST_WALK;
      if (state_q == ST_WALK) k_q <= (k_q == LAST_K) ? '0 : k_q + KW'(1);
      else k_q <= '0;
      if (q_pop_o && q_item_i.op == OP_BEGIN) begin
        cset_q  <= '0;
        cval_q  <= '0;
        worst_q <= LEN_C;
      end
      if (q_pop_o) acc_q <= '0;
      else if (p_vld_q) acc_q <= acc_nxt;
      if (p_vld_q) cval_q[p_idx_q] <= 1'b1;
      if (state_q == ST_DRAIN) begin
        cset_q[pos_q] <= 1'b1;
        worst_q       <= acc_nxt;
      end
      if (state_q == ST_RESULT && out_free) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign max_distance_o = out_max_q;

  a_begin_resets : assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o && q_item_i.op == OP_BEGIN |=> worst_q == LEN_C && cset_q == '0)
    else $error("begin did not restart the candidate");

  a_set_marks : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DRAIN |=> cset_q[$past(pos_q)])
    else $error("set position not marked after update");

  a_result_src : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_RESULT)
      && out_max_q == MAX_DIST_W'($past(worst_q)))
    else $error("result not taken from the current maximum");

  a_walk_stage : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DRAIN |-> p_vld_q && p_idx_q == LAST_K)
    else $error("walk ended before the last counter");

endmodule

[tb/sv/tb_closest_string_fitness_updater.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_closest_string_fitness_updater
// Self-checking bench for the closest-string fitness updater. Requests are
// driven over the valid/stall request channel with random gaps. Each accepted
// request runs through a local copy of the reference table, the candidate and
// the distance counters, and the expected maximum distance is queued. Every
// result taken from the output channel, under random stall, is compared with
// the oldest queued value.
// ----------------------------------------------------------------------------
module tb_closest_string_fitness_updater;
  import csfu_pkg::*;

  localparam int unsigned REFS        = 16;
  localparam int unsigned LENGTH      = 256;
  localparam int unsigned HALF_PERIOD = 2;
  localparam int unsigned RESET_CYCLES = 9;
  // worst case per item: the longest gap, a set walk and the longest stall
  localparam int unsigned CYCLE_LIMIT = 500000;
  // margin after the last result, longer than a set item's counter walk
  localparam int unsigned DRAIN_CYCLES = REFS + 8;
  localparam int unsigned RANDOM_ITEMS = 1200;
  localparam int unsigned MAX_PRINTED  = 100;

  // the package gives no name to the unused request code
  localparam logic [REQ_W-1:0] REQ_RESERVED = 2'd3;

  // ---------------------------------------------------------------- signals
  logic                  clk_i          = 1'b0;
  logic                  rst_ni         = 1'b0;
  logic                  in_valid_i     = 1'b0;
  logic                  in_stall_o;
  logic [REQ_W-1:0]      req_type_i     = '0;
  logic [REF_W-1:0]      ref_index_i    = '0;
  logic [POS_W-1:0]      position_i     = '0;
  logic [SYM_W-1:0]      symbol_i       = '0;
  logic                  out_valid_o;
  logic                  out_stall_i    = 1'b0;
  logic [MAX_DIST_W-1:0] max_distance_o;

  closest_string_fitness_updater #(
    .REFS   (REFS),
    .LENGTH (LENGTH)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .req_type_i     (req_type_i),
    .ref_index_i    (ref_index_i),
    .position_i     (position_i),
    .symbol_i       (symbol_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .max_distance_o (max_distance_o)
  );

  always #(HALF_PERIOD) clk_i = ~clk_i;

  // ------------------------------------------------------ shadow of the block
  // reference strings, and which entries were written so far
  logic [SYM_W-1:0]      ref_sym    [REFS][LENGTH];
  logic [LENGTH-1:0]     ref_known  [REFS];
  // candidate string and its set flags
  logic [SYM_W-1:0]      cand_sym   [LENGTH];
  logic [LENGTH-1:0]     cand_set;
  // one mismatch counter per reference and their maximum
  logic [MAX_DIST_W-1:0] dist_count [REFS];
  logic [MAX_DIST_W-1:0] worst_dist;

  // positions where every reference is written; only these may be set
  bit                    col_ready  [LENGTH];
  int unsigned           ready_pos  [$];

  // expected maximum distance for every accepted item, oldest first
  logic [MAX_DIST_W-1:0] max_dist_expected [$];

  int unsigned errors     = 0;
  int unsigned items_sent = 0;
  int unsigned cycles     = 0;

  // idling: each side waits a drawn gap per item, with quiet stretches
  bit          in_quiet  = 1'b0;
  bit          out_quiet = 1'b0;
  int unsigned out_hold  = 0;

  // ------------------------------------------------------------- predictor
  // applies one request to the shadow state, returns the maximum afterwards
  function automatic logic [MAX_DIST_W-1:0] predict_max_distance(
      input logic [REQ_W-1:0] req, input logic [REF_W-1:0] ridx,
      input logic [POS_W-1:0] pos, input logic [SYM_W-1:0] sym);
    logic [MAX_DIST_W-1:0] peak;
    logic                  was_match;
    logic                  now_match;
    bit                    all_known;
    peak = '0;
    case (req)
      REQ_LOAD: begin
        if (ridx < REFS && pos < LENGTH) begin
          ref_sym[ridx][pos]   = sym;
          ref_known[ridx][pos] = 1'b1;
          all_known = 1'b1;
          for (int k = 0; k < REFS; k++) all_known &= ref_known[k][pos];
          if (all_known && !col_ready[pos]) begin
            col_ready[pos] = 1'b1;
            ready_pos.push_back(pos);
          end
        end
      end
      REQ_BEGIN: begin
        cand_set = '0;
        for (int k = 0; k < REFS; k++) dist_count[k] = MAX_DIST_W'(LENGTH);
        worst_dist = MAX_DIST_W'(LENGTH);
      end
      REQ_SET: begin
        if (pos < LENGTH) begin
          // old match adds one back, new match takes one away, both saturate
          for (int k = 0; k < REFS; k++) begin
            was_match = cand_set[pos] && (ref_sym[k][pos] == cand_sym[pos]);
            now_match = (ref_sym[k][pos] == sym);
            if (was_match && !now_match && dist_count[k] < LENGTH)
              dist_count[k]++;
            else if (now_match && !was_match && dist_count[k] != 0)
              dist_count[k]--;
            if (dist_count[k] > peak) peak = dist_count[k];
          end
          cand_sym[pos] = sym;
          cand_set[pos] = 1'b1;
          worst_dist    = peak;
        end
      end
      default: begin
        // reserved code leaves everything alone
      end
    endcase
    return worst_dist;
  endfunction

  // ------------------------------------------------------------ randomness
  function automatic int unsigned draw_gap(inout bit quiet);
    if ($urandom_range(0, 39) == 0) quiet = !quiet;
    return quiet ? 0 : $urandom_range(0, 19);
  endfunction

  // a small alphabet keeps matches frequent; a raw byte now and then
  function automatic logic [SYM_W-1:0] pick_symbol();
    case ($urandom_range(0, 4))
      0: return SYM_W'($urandom_range(0, (1 << SYM_W) - 1));
      1: return 8'h00;
      2: return 8'hFF;
      3: return 8'h5A;
      default: return 8'hA5;
    endcase
  endfunction

  // ------------------------------------------------------------- reporting
  task automatic report_mismatch(input string what);
    if (errors < MAX_PRINTED) $display("[%0t] mismatch: %s", $realtime, what);
    errors++;
  endtask

  // -------------------------------------------------------------- driving
  // one request item; valid stays high across back-to-back items so that
  // it never gets two updates in one time step
  task automatic send_request(input logic [REQ_W-1:0] req,
                              input logic [REF_W-1:0] ridx,
                              input logic [POS_W-1:0] pos,
                              input logic [SYM_W-1:0] sym);
    int unsigned gap;
    gap = draw_gap(in_quiet);
    @(negedge clk_i);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    req_type_i  <= req;
    ref_index_i <= ridx;
    position_i  <= pos;
    symbol_i    <= sym;
    // in_stall_o is read before this edge's updates land
    do @(posedge clk_i); while (in_stall_o);
    max_dist_expected.push_back(predict_max_distance(req, ridx, pos, sym));
    items_sent++;
  endtask

  // all references at one position, either one shared symbol or mixed
  task automatic load_column(input logic [POS_W-1:0] pos,
                             input logic [SYM_W-1:0] sym, input bit uniform);
    for (int k = 0; k < REFS; k++)
      send_request(REQ_LOAD, REF_W'(k), pos, uniform ? sym : pick_symbol());
  endtask

  // --------------------------------------------------------------- results
  // result stall: held for a drawn number of cycles while a result waits
  always @(negedge clk_i) begin
    if (out_hold != 0) begin
      out_stall_i <= 1'b1;
      if (out_valid_o) out_hold--;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin : check_results
    logic [MAX_DIST_W-1:0] want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      out_hold = draw_gap(out_quiet);
      if (max_dist_expected.size() == 0) begin
        report_mismatch($sformatf("result max_distance=%0d with none expected",
                                  max_distance_o));
      end else begin
        want = max_dist_expected.pop_front();
        if (max_distance_o !== want)
          report_mismatch($sformatf("max_distance got %0d, want %0d",
                                    max_distance_o, want));
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("[%0t] timeout, %0d results outstanding", $realtime,
               max_dist_expected.size());
      $display("status: fail");
      $finish;
    end
  end

  // ----------------------------------------------------------------- tests
  // reserved code and begin right after reset: maximum stays at LENGTH
  task automatic test_idle_requests();
    send_request(REQ_RESERVED, '1, '1, '1);
    send_request(REQ_BEGIN, '0, '0, '0);
  endtask

  // every reference agrees at the last position, so the maximum moves
  task automatic test_uniform_column();
    load_column(8'hFF, 8'h00, 1'b1);
    send_request(REQ_SET, '0, 8'hFF, 8'hFF);  // no match anywhere
    send_request(REQ_SET, '0, 8'hFF, 8'h00);  // all match, max drops
    send_request(REQ_SET, '0, 8'hFF, 8'h00);  // same symbol again, no change
    send_request(REQ_SET, '0, 8'hFF, 8'hFF);  // old match lost, max back up
  endtask

  // a load under a live candidate leaves the counters alone; the later set
  // then pushes the top reference's counter against LENGTH
  task automatic test_reference_rewrite();
    send_request(REQ_BEGIN, 4'hF, 8'h00, 8'hFF);
    send_request(REQ_SET, 4'hF, 8'hFF, 8'h5A);
    send_request(REQ_LOAD, 4'hF, 8'hFF, 8'h5A);
    send_request(REQ_SET, 4'h0, 8'hFF, 8'hA5);  // saturates at LENGTH
    send_request(REQ_SET, 4'h0, 8'hFF, 8'h00);
    send_request(REQ_LOAD, 4'hF, 8'hFF, 8'h00);
    send_request(REQ_SET, 4'h0, 8'hFF, 8'h00);
  endtask

  // mostly columns followed by sets on ready positions, with begins, stray
  // loads that rewrite references under the candidate, and reserved codes
  task automatic test_random_traffic(input int unsigned n_items);
    int unsigned stop_at;
    int unsigned pick;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      pick = $urandom_range(0, 99);
      if (ready_pos.size() < 3 || pick < 4)
        load_column(POS_W'($urandom_range(0, LENGTH - 1)), pick_symbol(),
                    $urandom_range(0, 9) < 3);
      else if (pick < 12)
        send_request(REQ_LOAD, REF_W'($urandom_range(0, REFS - 1)),
                     POS_W'($urandom_range(0, LENGTH - 1)), pick_symbol());
      else if (pick < 17)
        send_request(REQ_BEGIN, REF_W'($urandom_range(0, REFS - 1)),
                     POS_W'($urandom_range(0, LENGTH - 1)), pick_symbol());
      else if (pick < 20)
        send_request(REQ_RESERVED, REF_W'($urandom_range(0, REFS - 1)),
                     POS_W'($urandom_range(0, LENGTH - 1)), pick_symbol());
      else
        send_request(REQ_SET, REF_W'($urandom_range(0, REFS - 1)),
                     POS_W'(ready_pos[$urandom_range(0, ready_pos.size() - 1)]),
                     pick_symbol());
    end
  endtask

  // ------------------------------------------------------------- sequence
  initial begin
    // shadow state as after reset
    cand_set   = '0;
    worst_dist = MAX_DIST_W'(LENGTH);
    for (int k = 0; k < REFS; k++) begin
      dist_count[k] = MAX_DIST_W'(LENGTH);
      ref_known[k]  = '0;
    end
    for (int p = 0; p < LENGTH; p++) col_ready[p] = 1'b0;

    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_idle_requests();
    test_uniform_column();
    test_reference_rewrite();
    test_random_traffic(RANDOM_ITEMS);

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (max_dist_expected.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
